// ===== hw/rtl/gde_pkg.sv =====
// shared types and constants for the gamepad deadzone and button edge block
package gde_pkg;

    localparam int PAD_COUNT = 4;
    localparam int PAD_W = 2;
    localparam int AXIS_W = 16;
    localparam int DZ_W = 15;
    localparam int MASK_W = 24;
    localparam int CFG_IDX_W = 4;

    localparam logic [DZ_W-1:0] DEADZONE_RESET = 15'h2710;
    localparam logic [DZ_W-1:0] RANGE_RESET = 15'h7FFF;
    localparam logic [7:0] TRIGGER_LIMIT = 8'h7F;
    localparam logic [15:0] BUTTON_KEEP = 16'hF3FF;

    // derived from the reset register values
    localparam logic [DZ_W-1:0] EFF_RESET = RANGE_RESET - DEADZONE_RESET;
    localparam logic [DZ_W:0] THR_RESET = {2'b00, EFF_RESET[DZ_W-1:1]} + {1'b0, DEADZONE_RESET};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEADZONE  = 4'd0,
        REG_RANGE_MAX = 4'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        LINK_NONE = 2'd0,
        LINK_UP   = 2'd1,
        LINK_DOWN = 2'd2
    } link_event_t;

    typedef enum logic [1:0] {
        FS_NONE  = 2'b00,
        FS_PLUS  = 2'b01,
        FS_MINUS = 2'b10
    } full_scale_t;

    typedef struct packed {
        logic [PAD_W-1:0]         pad;
        logic                     connected;
        logic [15:0]              raw_buttons;
        logic [7:0]               left_trigger_in;
        logic [7:0]               right_trigger_in;
        logic signed [AXIS_W-1:0] left_stick_x;
        logic signed [AXIS_W-1:0] left_stick_y;
        logic signed [AXIS_W-1:0] right_stick_x;
        logic signed [AXIS_W-1:0] right_stick_y;
    } sample_t;

    typedef struct packed {
        logic [MASK_W-1:0]        held_mask;
        logic [MASK_W-1:0]        pressed_mask;
        logic [MASK_W-1:0]        released_mask;
        logic [7:0]               left_trigger_out;
        logic [7:0]               right_trigger_out;
        logic signed [AXIS_W-1:0] adj_left_x;
        logic signed [AXIS_W-1:0] adj_left_y;
        logic signed [AXIS_W-1:0] adj_right_x;
        logic signed [AXIS_W-1:0] adj_right_y;
        logic [7:0]               full_scale_flags;
        logic [1:0]               link_event;
    } result_t;

endpackage

// ===== hw/rtl/gamepad_deadzone_button_edges.sv =====
// gamepad sample conditioner: deadzone removal, direction buttons, edge and link events
//
// One sample beat in, one result beat out. A sample is captured in an input
// register, conditioned by one level of compare/subtract logic and stored in
// the result register, so the block takes one sample per cycle while the
// output is not stalled. The per-pad previous-held and connection state is a
// small flop array updated as each sample moves to the result register, so
// samples of the same pad may follow each other in consecutive cycles.
// Effective range and direction threshold are recomputed when a register is
// written and take effect at that clock edge, for every sample that moves to
// the result register after it.
module gamepad_deadzone_button_edges
    import gde_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DZ_W-1:0]      cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sample_t              in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output result_t              out_data
);

    localparam int WIDE_W = AXIS_W + 2;

    logic [DZ_W-1:0] dz_reg, dz_next;
    logic [DZ_W-1:0] rmax_reg, rmax_next;
    logic [DZ_W-1:0] eff_reg, eff_next;
    logic [DZ_W:0]   thr_reg, thr_next;

    logic [MASK_W-1:0] prev_held_reg [PAD_COUNT];
    logic              was_conn_reg [PAD_COUNT];

    logic    s1_valid_reg;
    sample_t s1_data_reg;
    logic    out_valid_reg;
    result_t out_data_reg;

    logic    out_free;
    logic    s1_adv;
    logic    pad_ok;
    result_t res_next;
    logic [MASK_W-1:0] held;
    logic [MASK_W-1:0] prev;
    logic              was_conn;

    logic signed [AXIS_W-1:0] ax [4];
    logic signed [WIDE_W-1:0] ax_w [4];
    logic signed [WIDE_W-1:0] adj_w [4];
    logic signed [AXIS_W-1:0] adj [4];
    logic [1:0]               fs [4];
    logic signed [WIDE_W-1:0] thr_w, dz_w, eff_w;

    // configuration and derived thresholds
    always_comb
    begin
        dz_next = dz_reg;
        rmax_next = rmax_reg;
        if (cfg_wr_en)
        begin
            if (cfg_index == REG_DEADZONE)
                dz_next = cfg_data;
            else if (cfg_index == REG_RANGE_MAX)
                rmax_next = cfg_data;
        end
        eff_next = (rmax_next > dz_next) ? DZ_W'(rmax_next - dz_next) : '0;
        thr_next = {2'b00, eff_next[DZ_W-1:1]} + {1'b0, dz_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg <= DEADZONE_RESET;
            rmax_reg <= RANGE_RESET;
            eff_reg <= EFF_RESET;
            thr_reg <= THR_RESET;
        end
        else
        begin
            dz_reg <= dz_next;
            rmax_reg <= rmax_next;
            eff_reg <= eff_next;
            thr_reg <= thr_next;
        end
    end

    // pipeline flow
    assign out_free = !out_valid_reg || out_ready;
    assign s1_adv = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    assign pad_ok = (int'(s1_data_reg.pad) < PAD_COUNT);
    assign prev = prev_held_reg[s1_data_reg.pad];
    assign was_conn = was_conn_reg[s1_data_reg.pad];

    assign thr_w = WIDE_W'(signed'({1'b0, thr_reg}));
    assign dz_w = WIDE_W'(signed'({1'b0, dz_reg}));
    assign eff_w = WIDE_W'(signed'({1'b0, eff_reg}));

    assign ax[0] = s1_data_reg.left_stick_x;
    assign ax[1] = s1_data_reg.left_stick_y;
    assign ax[2] = s1_data_reg.right_stick_x;
    assign ax[3] = s1_data_reg.right_stick_y;

    always_comb
    begin
        held = '0;
        held[15:0] = s1_data_reg.raw_buttons & BUTTON_KEEP;
        held[10] = s1_data_reg.left_trigger_in > TRIGGER_LIMIT;
        held[11] = s1_data_reg.right_trigger_in > TRIGGER_LIMIT;
        for (int i = 0; i < 4; i++)
        begin
            ax_w[i] = WIDE_W'(ax[i]);
            held[16 + 2*i] = ax_w[i] > thr_w;
            held[17 + 2*i] = ax_w[i] < -thr_w;
            if (ax_w[i] > dz_w)
                adj_w[i] = ax_w[i] - dz_w;
            else if (ax_w[i] >= -dz_w)
                adj_w[i] = '0;
            else
                adj_w[i] = ax_w[i] + dz_w;
            adj[i] = adj_w[i][AXIS_W-1:0];
            // zero effective range never flags
            if (eff_reg == '0)
                fs[i] = FS_NONE;
            else if (adj_w[i] >= eff_w)
                fs[i] = FS_PLUS;
            else if (adj_w[i] <= -eff_w)
                fs[i] = FS_MINUS;
            else
                fs[i] = FS_NONE;
        end
    end

    always_comb
    begin
        res_next = '0;
        if (pad_ok)
        begin
            if (s1_data_reg.connected && !was_conn)
                res_next.link_event = LINK_UP;
            else if (!s1_data_reg.connected && was_conn)
                res_next.link_event = LINK_DOWN;
            else
                res_next.link_event = LINK_NONE;
            if (s1_data_reg.connected)
            begin
                res_next.held_mask = held;
                res_next.pressed_mask = held & ~prev;
                res_next.released_mask = prev & ~held;
                res_next.left_trigger_out = s1_data_reg.left_trigger_in;
                res_next.right_trigger_out = s1_data_reg.right_trigger_in;
                res_next.adj_left_x = adj[0];
                res_next.adj_left_y = adj[1];
                res_next.adj_right_x = adj[2];
                res_next.adj_right_y = adj[3];
                res_next.full_scale_flags = {fs[3], fs[2], fs[1], fs[0]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < PAD_COUNT; i++)
            begin
                prev_held_reg[i] <= '0;
                was_conn_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
            // per-pad state follows the beat into the result register
            if (s1_adv && pad_ok)
            begin
                was_conn_reg[s1_data_reg.pad] <= s1_data_reg.connected;
                prev_held_reg[s1_data_reg.pad] <= s1_data_reg.connected ? held : '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_data_reg <= in_data;
        if (s1_adv)
            out_data_reg <= res_next;
    end

endmodule
